### sv/gfct_pkg.sv
`default_nettype none
package gfct_pkg;

  localparam int LABEL_W = 32;
  localparam int COUNT_W = 8;
  localparam int RND_W   = 31;
  localparam int LOC_W   = 10;
  localparam int SLOT_DW = LABEL_W + COUNT_W;

  // Input kinds.
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_EXISTS = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // Result actions.
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_EXISTS = 2'd2;
  localparam logic [1:0] ACT_SLOT   = 2'd3;

  // Hash constants.
  localparam logic [31:0] HASH_SEED = 32'd10;
  localparam logic [31:0] HASH_C1   = 32'hcc9e2d51;
  localparam logic [31:0] HASH_C2   = 32'h1b873593;
  localparam logic [31:0] HASH_M5   = 32'd5;
  localparam logic [31:0] HASH_ADD  = 32'he6546b64;
  localparam logic [31:0] HASH_LEN  = 32'd4;
  localparam logic [31:0] HASH_F1   = 32'h85ebca6b;
  localparam logic [31:0] HASH_F2   = 32'hc2b2ae35;

  typedef logic [255:0][31:0] decay_rom_t;

  // floor(1.08^n) built in 32.96 fixed point: v = trunc(v / 25) * 27.
  function automatic decay_rom_t decay_rom_build();
    decay_rom_t  rom;
    logic [127:0] acc;
    rom    = '0;
    acc    = 128'd1 << 96;
    rom[0] = 32'd1;
    for (int n = 1; n < 256; n++) begin
      acc    = acc / 128'd25;
      acc    = acc * 128'd27;
      rom[n] = (acc[127:96] != 32'd0) ? acc[127:96] : 32'd1;
    end
    return rom;
  endfunction

  localparam decay_rom_t DECAY_ROM = decay_rom_build();

endpackage
`default_nettype wire

### sv/gfct_ram.sv
`default_nettype none
module gfct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                     wdata,
  input  wire                                  re,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/gfct_hash.sv
`default_nettype none
module gfct_hash
  import gfct_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [31:0] key,
  output logic        done,
  output logic [31:0] hash
);

  // One 32-bit register and one constant multiplier, stepped through the
  // MurmurHash3 word mix and finalizer.
  localparam logic [3:0] LAST_STEP = 4'd10;

  logic        active;
  logic [3:0]  step;
  logic [31:0] x;
  logic [31:0] x_next;
  logic [31:0] mul_k;
  logic [31:0] prod;
  logic [31:0] sum;

  assign hash = x;

  always_comb begin
    case (step)
      4'd0:    mul_k = HASH_C1;
      4'd2:    mul_k = HASH_C2;
      4'd4:    mul_k = HASH_M5;
      4'd7:    mul_k = HASH_F1;
      4'd9:    mul_k = HASH_F2;
      default: mul_k = HASH_C1;
    endcase
    prod = x * mul_k;
    sum  = x + HASH_ADD;
    case (step)
      4'd0, 4'd2, 4'd4, 4'd7, 4'd9: x_next = prod;
      4'd1:    x_next = {x[16:0], x[31:17]};
      4'd3:    x_next = {x[18:0] ^ HASH_SEED[18:0], x[31:19] ^ HASH_SEED[31:19]};
      4'd5:    x_next = sum ^ HASH_LEN;
      4'd6:    x_next = x ^ (x >> 16);
      4'd8:    x_next = x ^ (x >> 13);
      4'd10:   x_next = x ^ (x >> 16);
      default: x_next = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 4'd1;
        if (step == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= key;
    end else if (active) begin
      x <= x_next;
    end
  end

endmodule
`default_nettype wire

### sv/gfct_mod.sv
`default_nettype none
module gfct_mod (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [31:0] dividend,
  input  wire  [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  // Restoring remainder, one dividend bit per cycle.
  logic        active;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [32:0] trial;

  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (active) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= 32'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[31:0];
      end
    end
  end

endmodule
`default_nettype wire

### sv/grouped_flow_counter_table.sv
`default_nettype none
// Grouped flow counter table.
//
// An item is a transfer on the command channel: it is taken at a rising edge
// where start is high and busy is low. Kind update hashes the flow label,
// finds its group of GROUP_SIZE slots and raises, fills or decays a slot;
// kind exists answers whether the label is held; kind read returns one slot.
// Kind no-op is taken and does nothing.
// Results appear on the result ports for exactly one cycle with valid high;
// last marks the final result of an item. The receiver cannot stall, so
// every result is a transfer in the cycle it is shown.
// A read fetches its slot and then shows its result; a no-op never raises
// busy. Updates and exists queries pass the hash unit, the group index
// (reciprocal multiply and one correction), the fill count read, and a read
// and a check of each slot on the scan of the slot memory before the
// result shows. A full group adds the bit-serial decay remainder; a decay
// that does not replace shows no result, and a replacement shows a clear
// and then the update as its second result.
// Busy drops in the cycle that shows the last result. After reset a clearing
// pass zeroes every slot and fill count.
module grouped_flow_counter_table
  import gfct_pkg::*;
#(
  parameter int GROUP_SIZE = 4,
  parameter int NUM_GROUPS = 256,
  parameter int COUNT_MAX  = 255
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  kind,
  input  wire  [31:0] flow_label,
  input  wire  [31:0] partner_label,
  input  wire  [30:0] random_value,
  input  wire  [9:0]  slot_location,
  output logic        valid,
  output logic [1:0]  action,
  output logic [9:0]  slot_index,
  output logic [31:0] hash_value,
  output logic [31:0] partner_out,
  output logic        found,
  output logic [31:0] slot_label,
  output logic [7:0]  slot_count,
  output logic        last
);

  localparam int TABLE_SLOTS = GROUP_SIZE * NUM_GROUPS;
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int GRP_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int FILL_W = $clog2(GROUP_SIZE + 1);

  // A power-of-two group count is a mask; any other count uses the
  // truncated reciprocal, whose quotient is at most one short.
  localparam bit GRP_POW2 = ((NUM_GROUPS & (NUM_GROUPS - 1)) == 0);
  localparam logic [31:0] GRP_RECIP =
    GRP_POW2 ? 32'd0 : 32'(64'h1_0000_0000 / 64'(NUM_GROUPS));

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_HASH     = 4'd2;
  localparam logic [3:0] ST_GRP      = 4'd3;
  localparam logic [3:0] ST_FILL_RD  = 4'd4;
  localparam logic [3:0] ST_FILL_GET = 4'd5;
  localparam logic [3:0] ST_SCAN_RD  = 4'd6;
  localparam logic [3:0] ST_SCAN_CHK = 4'd7;
  localparam logic [3:0] ST_DECIDE   = 4'd8;
  localparam logic [3:0] ST_DECAY    = 4'd9;
  localparam logic [3:0] ST_UPD2     = 4'd10;
  localparam logic [3:0] ST_READ     = 4'd11;

  logic [3:0]        state;
  logic [SLOT_W-1:0] clr_addr;
  logic [1:0]        kind_r;
  logic [31:0]       label_r;
  logic [31:0]       partner_r;
  logic [30:0]       rnd_r;
  logic [9:0]        loc_r;
  logic              loc_ok;
  logic [31:0]       hash_r;
  logic [GRP_W-1:0]  grp_r;
  logic [SLOT_W-1:0] base_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] scan_i;
  logic              hit_f;
  logic [FILL_W-1:0] hit_i;
  logic [7:0]        hit_cnt;
  logic [FILL_W-1:0] min_i;
  logic [7:0]        min_cnt;
  // The decay write keeps the old label; hold it from the scan.
  logic [31:0]       min_label;

  // Group index sequence.
  logic [1:0]        grp_step;
  logic [31:0]       grp_acc;
  logic [63:0]       grp_prod;
  logic [31:0]       grp_back;
  logic [GRP_W-1:0]  grp_sel;

  // Slot memory holds {label, count}.
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_waddr;
  logic [SLOT_DW-1:0] slot_wdata;
  logic               slot_re;
  logic [SLOT_W-1:0]  slot_raddr;
  logic [SLOT_DW-1:0] slot_rdata;
  logic               fill_we;
  logic [GRP_W-1:0]   fill_waddr;
  logic [FILL_W-1:0]  fill_wdata;
  logic               fill_re;
  logic [FILL_W-1:0]  fill_rdata;

  logic        hash_go;
  logic        hash_done;
  logic [31:0] hash_out;
  logic        mod_start;
  logic [31:0] mod_dividend;
  logic [31:0] mod_divisor;
  logic        mod_done;
  logic [31:0] mod_rem;

  logic              accept;
  logic [31:0]       rd_label;
  logic [7:0]        rd_count;
  logic [SLOT_W-1:0] hit_addr;
  logic [SLOT_W-1:0] min_addr;
  logic [SLOT_W-1:0] free_addr;
  logic [7:0]        inc_cnt;
  logic              group_full;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign rd_label   = slot_rdata[SLOT_DW-1:COUNT_W];
  assign rd_count   = slot_rdata[COUNT_W-1:0];
  assign hit_addr   = SLOT_W'(base_r + SLOT_W'(hit_i));
  assign min_addr   = SLOT_W'(base_r + SLOT_W'(min_i));
  assign free_addr  = SLOT_W'(base_r + SLOT_W'(fill_r));
  assign inc_cnt    = (hit_cnt < 8'(COUNT_MAX)) ? 8'(hit_cnt + 8'd1) : hit_cnt;
  assign group_full = (32'(fill_r) >= GROUP_SIZE);

  // Quotient estimate, its product back with the group count, and the final
  // correction of a remainder that is below twice the group count.
  assign grp_prod = 64'(hash_r) * 64'(GRP_RECIP);
  assign grp_back = grp_acc * 32'(NUM_GROUPS);
  assign grp_sel  = GRP_POW2 ? GRP_W'(hash_r & 32'(NUM_GROUPS - 1))
                             : GRP_W'((grp_acc >= 32'(NUM_GROUPS)) ?
                                      grp_acc - 32'(NUM_GROUPS) : grp_acc);

  // Memory ports and shared-unit requests.
  always_comb begin
    slot_we      = 1'b0;
    slot_waddr   = clr_addr;
    slot_wdata   = '0;
    slot_re      = 1'b0;
    slot_raddr   = SLOT_W'(base_r + SLOT_W'(scan_i));
    fill_we      = 1'b0;
    fill_waddr   = grp_r;
    fill_wdata   = '0;
    fill_re      = 1'b0;
    hash_go      = 1'b0;
    mod_start    = 1'b0;
    mod_dividend = 32'(rnd_r);
    mod_divisor  = DECAY_ROM[min_cnt];
    case (state)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        fill_we    = (32'(clr_addr) < NUM_GROUPS);
        fill_waddr = GRP_W'(clr_addr);
      end
      ST_IDLE: begin
        if (accept && kind == KIND_READ) begin
          slot_re    = 1'b1;
          slot_raddr = SLOT_W'(slot_location);
        end
        hash_go = accept && (kind == KIND_UPDATE || kind == KIND_EXISTS);
      end
      ST_FILL_RD: begin
        fill_re = 1'b1;
      end
      ST_SCAN_RD: begin
        slot_re = 1'b1;
      end
      ST_DECIDE: begin
        if (kind_r == KIND_UPDATE) begin
          if (hit_f) begin
            slot_we    = 1'b1;
            slot_waddr = hit_addr;
            slot_wdata = {label_r, inc_cnt};
          end else if (!group_full) begin
            slot_we    = 1'b1;
            slot_waddr = free_addr;
            slot_wdata = {label_r, 8'd1};
            fill_we    = 1'b1;
            fill_wdata = FILL_W'(fill_r + FILL_W'(1));
          end else begin
            mod_start = 1'b1;
          end
        end
      end
      ST_DECAY: begin
        if (mod_done && mod_rem == 32'd0) begin
          slot_we    = 1'b1;
          slot_waddr = min_addr;
          if (min_cnt <= 8'd1) begin
            slot_wdata = {label_r, 8'd1};
          end else begin
            slot_wdata = {min_label, 8'(min_cnt - 8'd1)};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      valid    <= 1'b0;
      last     <= 1'b0;
    end else begin
      valid <= 1'b0;
      last  <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= SLOT_W'(clr_addr + SLOT_W'(1));
          if (32'(clr_addr) == TABLE_SLOTS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (kind == KIND_READ) begin
              state <= ST_READ;
            end else if (kind == KIND_UPDATE || kind == KIND_EXISTS) begin
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            state <= ST_GRP;
          end
        end
        ST_GRP: begin
          if (grp_step == 2'd3) begin
            state <= ST_FILL_RD;
          end
        end
        ST_FILL_RD: begin
          state <= ST_FILL_GET;
        end
        ST_FILL_GET: begin
          state <= ST_SCAN_RD;
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (32'(scan_i) == GROUP_SIZE - 1) begin
            state <= ST_DECIDE;
          end else begin
            state <= ST_SCAN_RD;
          end
        end
        ST_DECIDE: begin
          if (kind_r == KIND_EXISTS) begin
            valid <= 1'b1;
            last  <= 1'b1;
            state <= ST_IDLE;
          end else if (hit_f || !group_full) begin
            valid <= 1'b1;
            last  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_DECAY;
          end
        end
        ST_DECAY: begin
          if (mod_done) begin
            if (mod_rem == 32'd0 && min_cnt <= 8'd1) begin
              valid <= 1'b1;
              state <= ST_UPD2;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_UPD2: begin
          valid <= 1'b1;
          last  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_READ: begin
          valid <= 1'b1;
          last  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item registers, scan bookkeeping and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= kind;
      label_r   <= flow_label;
      partner_r <= partner_label;
      rnd_r     <= random_value;
      loc_r     <= slot_location;
      loc_ok    <= (32'(slot_location) < TABLE_SLOTS);
    end
    if (state == ST_HASH && hash_done) begin
      hash_r   <= hash_out;
      grp_step <= '0;
    end
    if (state == ST_GRP) begin
      grp_step <= 2'(grp_step + 2'd1);
      case (grp_step)
        2'd0:    grp_acc <= grp_prod[63:32];
        2'd1:    grp_acc <= grp_back;
        2'd2:    grp_acc <= hash_r - grp_acc;
        default: grp_r   <= grp_sel;
      endcase
    end
    if (state == ST_FILL_GET) begin
      base_r  <= SLOT_W'(32'(grp_r) * GROUP_SIZE);
      fill_r  <= (32'(fill_rdata) > GROUP_SIZE) ? FILL_W'(GROUP_SIZE) : fill_rdata;
      scan_i  <= '0;
      hit_f   <= 1'b0;
      hit_i   <= '0;
      hit_cnt <= '0;
    end
    if (state == ST_SCAN_CHK) begin
      if (!hit_f && scan_i < fill_r && rd_label == label_r) begin
        hit_f   <= 1'b1;
        hit_i   <= scan_i;
        hit_cnt <= rd_count;
      end
      if (scan_i == '0 || rd_count < min_cnt) begin
        min_i     <= scan_i;
        min_cnt   <= rd_count;
        min_label <= rd_label;
      end
      scan_i <= FILL_W'(scan_i + FILL_W'(1));
    end

    case (state)
      ST_DECIDE: begin
        hash_value  <= hash_r;
        slot_label  <= '0;
        slot_count  <= '0;
        if (kind_r == KIND_EXISTS) begin
          action      <= ACT_EXISTS;
          slot_index  <= hit_f ? 10'(hit_addr) : 10'd0;
          partner_out <= '0;
          found       <= hit_f;
        end else begin
          action      <= ACT_UPDATE;
          slot_index  <= hit_f ? 10'(hit_addr) : 10'(free_addr);
          partner_out <= partner_r;
          found       <= 1'b0;
        end
      end
      ST_DECAY: begin
        action      <= ACT_CLEAR;
        slot_index  <= 10'(min_addr);
        hash_value  <= hash_r;
        partner_out <= '0;
        found       <= 1'b0;
        slot_label  <= '0;
        slot_count  <= '0;
      end
      ST_UPD2: begin
        action      <= ACT_UPDATE;
        partner_out <= partner_r;
      end
      ST_READ: begin
        action      <= ACT_SLOT;
        slot_index  <= loc_r;
        hash_value  <= '0;
        partner_out <= '0;
        found       <= 1'b0;
        slot_label  <= loc_ok ? rd_label : 32'd0;
        slot_count  <= loc_ok ? rd_count : 8'd0;
      end
      default: begin
      end
    endcase
  end

  gfct_ram #(
    .WIDTH(SLOT_DW),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re   (slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  gfct_ram #(
    .WIDTH(FILL_W),
    .DEPTH(NUM_GROUPS)
  ) u_fill_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_waddr),
    .wdata(fill_wdata),
    .re   (fill_re),
    .raddr(grp_r),
    .rdata(fill_rdata)
  );

  gfct_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(hash_go),
    .key  (flow_label),
    .done (hash_done),
    .hash (hash_out)
  );

  gfct_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(mod_dividend),
    .divisor (mod_divisor),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // A bucket clear is always followed at once by the matching update.
  a_clear_then_update: assert property (@(posedge clk) disable iff (rst)
    (valid && action == ACT_CLEAR) |=> (valid && action == ACT_UPDATE && last))
    else $error("bucket clear not followed by update");

  // Only a bucket clear is a non-final result.
  a_clear_not_last: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |-> (action == ACT_CLEAR))
    else $error("non-final result that is not a clear");

  // A no-op item produces no result.
  a_nop_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_NOP) |=> !valid)
    else $error("result after no-op item");

  // No item is taken during the clearing pass.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> busy)
    else $error("ready during clearing pass");

endmodule
`default_nettype wire

### tb/sv/grouped_flow_counter_table_tb.sv
`default_nettype none
module grouped_flow_counter_table_tb;
  import gfct_pkg::*;

  // The table geometry of the instance under test.
  localparam int GROUP_SIZE = 4;
  localparam int NUM_GROUPS = 256;
  localparam int COUNT_MAX  = 255;
  localparam int TABLE_SLOTS = GROUP_SIZE * NUM_GROUPS;

  // One result transfer, with its fields in port order.
  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  slot_index;
    logic [31:0] hash_value;
    logic [31:0] partner_out;
    logic        found;
    logic [31:0] slot_label;
    logic [7:0]  slot_count;
    logic        last;
  } table_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [31:0] flow_label;
  logic [31:0] partner_label;
  logic [30:0] random_value;
  logic [9:0]  slot_location;
  logic        valid;
  logic [1:0]  action;
  logic [9:0]  slot_index;
  logic [31:0] hash_value;
  logic [31:0] partner_out;
  logic        found;
  logic [31:0] slot_label;
  logic [7:0]  slot_count;
  logic        last;

  grouped_flow_counter_table #(
    .GROUP_SIZE(GROUP_SIZE),
    .NUM_GROUPS(NUM_GROUPS),
    .COUNT_MAX (COUNT_MAX)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .flow_label   (flow_label),
    .partner_label(partner_label),
    .random_value (random_value),
    .slot_location(slot_location),
    .valid        (valid),
    .action       (action),
    .slot_index   (slot_index),
    .hash_value   (hash_value),
    .partner_out  (partner_out),
    .found        (found),
    .slot_label   (slot_label),
    .slot_count   (slot_count),
    .last         (last)
  );

  // Shadow copy of the table, kept in step with every accepted command.
  logic [31:0] shadow_labels [TABLE_SLOTS];
  logic [7:0]  shadow_counts [TABLE_SLOTS];
  int          shadow_fill   [NUM_GROUPS];
  logic [31:0] decay_divisor [256];

  // Results that the shadow table says are still to come, oldest first.
  table_result_t pending_results[$];
  int            mismatches;

  // Sender pacing: items go out in bursts, with idle gaps between bursts
  // unless a gap-free stretch is running.
  int burst_left;
  bit no_gaps;

  // Labels that share a handful of groups, so that groups fill up and churn.
  logic [31:0] crowd_labels[$];
  logic [31:0] group_labels[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // MurmurHash3 x86_32 of one little-endian 32-bit word, seed 10.
  function automatic logic [31:0] flow_hash(input logic [31:0] key);
    logic [31:0] k;
    logic [31:0] h;
    k = key * 32'hcc9e2d51;
    k = {k[16:0], k[31:17]};
    k = k * 32'h1b873593;
    h = 32'd10 ^ k;
    h = {h[18:0], h[31:19]};
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic int group_of(input logic [31:0] label);
    return int'(flow_hash(label) % NUM_GROUPS);
  endfunction

  // The decay divisor table holds floor(1.08^n), grown in 32.96 fixed point
  // by dividing by 25 and then multiplying by 27 at each step.
  task automatic build_decay_divisors();
    logic [127:0] growth;
    growth = 128'd1 << 96;
    decay_divisor[0] = 32'd1;
    for (int n = 1; n < 256; n++) begin
      growth = (growth / 128'd25) * 128'd27;
      decay_divisor[n] = (growth[127:96] == 32'd0) ? 32'd1 : growth[127:96];
    end
  endtask

  function automatic table_result_t make_result(input logic [1:0] act,
                                                input int slot,
                                                input logic [31:0] hash,
                                                input logic [31:0] partner);
    table_result_t r;
    r = '0;
    r.action      = act;
    r.slot_index  = slot[9:0];
    r.hash_value  = hash;
    r.partner_out = partner;
    return r;
  endfunction

  // Applies one accepted command to the shadow table and queues the results
  // that it must produce.
  task automatic table_apply(input logic [1:0] cmd, input logic [31:0] label,
                             input logic [31:0] partner, input logic [30:0] rnd,
                             input logic [9:0] loc);
    table_result_t outcome[2];
    int            n;
    int            hit;
    int            base;
    int            fill;
    int            s;
    logic [31:0]   hash;
    n   = 0;
    hit = -1;
    if (cmd == KIND_READ) begin
      outcome[0] = make_result(ACT_SLOT, int'(loc), 32'd0, 32'd0);
      outcome[0].slot_label = shadow_labels[loc];
      outcome[0].slot_count = shadow_counts[loc];
      n = 1;
    end else if (cmd != KIND_NOP) begin
      hash = flow_hash(label);
      base = int'(hash % NUM_GROUPS) * GROUP_SIZE;
      fill = shadow_fill[int'(hash % NUM_GROUPS)];
      // Only filled slots can match, so label zero never hits an empty slot.
      for (int i = 0; i < fill; i++)
        if (hit < 0 && shadow_labels[base + i] == label)
          hit = i;
      if (cmd == KIND_EXISTS) begin
        outcome[0] = make_result(ACT_EXISTS, (hit >= 0) ? base + hit : 0, hash, 32'd0);
        outcome[0].found = (hit >= 0);
        n = 1;
      end else if (hit >= 0) begin
        s = base + hit;
        if (shadow_counts[s] < COUNT_MAX)
          shadow_counts[s] = shadow_counts[s] + 8'd1;
        outcome[0] = make_result(ACT_UPDATE, s, hash, partner);
        n = 1;
      end else if (fill < GROUP_SIZE) begin
        s = base + fill;
        shadow_labels[s] = label;
        shadow_counts[s] = 8'd1;
        shadow_fill[int'(hash % NUM_GROUPS)] = fill + 1;
        outcome[0] = make_result(ACT_UPDATE, s, hash, partner);
        n = 1;
      end else begin
        // Full group: the weakest slot (lowest index on ties) may decay,
        // and is taken over once it would drop to zero.
        s = base;
        for (int i = 1; i < GROUP_SIZE; i++)
          if (shadow_counts[base + i] < shadow_counts[s])
            s = base + i;
        if ({1'b0, rnd} % decay_divisor[shadow_counts[s]] == 32'd0) begin
          if (shadow_counts[s] <= 8'd1) begin
            outcome[0] = make_result(ACT_CLEAR, s, hash, 32'd0);
            outcome[1] = make_result(ACT_UPDATE, s, hash, partner);
            n = 2;
            shadow_labels[s] = label;
            shadow_counts[s] = 8'd1;
          end else begin
            shadow_counts[s] = shadow_counts[s] - 8'd1;
          end
        end
      end
    end
    if (n > 0)
      outcome[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++)
      pending_results.push_back(outcome[i]);
  endtask

  // Presents one command and holds it until the block takes it. The start
  // line is only lowered for an idle gap, never in the step that raises it.
  task automatic send_command(input logic [1:0] cmd, input logic [31:0] label,
                              input logic [31:0] partner, input logic [30:0] rnd,
                              input logic [9:0] loc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start         <= 1'b1;
    kind          <= cmd;
    flow_label    <= label;
    partner_label <= partner;
    random_value  <= rnd;
    slot_location <= loc;
    do @(posedge clk); while (busy);
    table_apply(cmd, label, partner, rnd, loc);
  endtask

  function automatic logic [30:0] any_random();
    return 31'($urandom());
  endfunction

  // Fills group_labels with cnt distinct labels that all hash to group g.
  task automatic gather_group(input int g, input int cnt);
    logic [31:0] probe;
    group_labels.delete();
    probe = $urandom();
    while (group_labels.size() < cnt) begin
      if (group_of(probe) == g)
        group_labels.push_back(probe);
      probe = probe + 32'd1;
    end
  endtask

  // Reads and queries on a fresh table, plus the command that does nothing.
  task automatic test_empty_table();
    send_command(KIND_READ, 32'd0, 32'd0, 31'd0, 10'd0);
    send_command(KIND_READ, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 10'h3ff);
    send_command(KIND_EXISTS, 32'd0, 32'd0, 31'd0, 10'd0);
    send_command(KIND_NOP, 32'hffffffff, 32'hffffffff, 31'h7fffffff, 10'h3ff);
  endtask

  // Label zero is a real label once stored, and all-ones fields pass through.
  task automatic test_extreme_labels();
    send_command(KIND_UPDATE, 32'd0, 32'hffffffff, 31'h7fffffff, 10'h3ff);
    send_command(KIND_EXISTS, 32'd0, 32'd0, 31'd0, 10'd0);
    send_command(KIND_READ, 32'd0, 32'd0, 31'd0, 10'(group_of(32'd0) * GROUP_SIZE));
    send_command(KIND_UPDATE, 32'hffffffff, 32'd0, 31'd0, 10'd0);
    send_command(KIND_UPDATE, 32'hffffffff, 32'h5a5a5a5a, 31'd1, 10'd0);
  endtask

  // Fill one group, take over its weakest slot, then decay a slot without
  // replacing it and finally replace it.
  task automatic test_full_group();
    int g;
    g = $urandom_range(0, NUM_GROUPS - 1);
    gather_group(g, 6);
    for (int i = 0; i < 4; i++)
      send_command(KIND_UPDATE, group_labels[i], $urandom(), any_random(), 10'd0);
    // Minimum count one: the newcomer replaces the first slot directly.
    send_command(KIND_UPDATE, group_labels[4], $urandom(), 31'd1, 10'd0);
    for (int i = 1; i < 4; i++)
      send_command(KIND_UPDATE, group_labels[i], $urandom(), any_random(), 10'd0);
    send_command(KIND_UPDATE, group_labels[4], $urandom(), any_random(), 10'd0);
    // All counts are now two: the next miss only decays.
    send_command(KIND_UPDATE, group_labels[5], $urandom(), 31'd0, 10'd0);
    send_command(KIND_UPDATE, group_labels[5], $urandom(), 31'd0, 10'd0);
    send_command(KIND_EXISTS, group_labels[5], 32'd0, 31'd0, 10'd0);
    send_command(KIND_EXISTS, group_labels[0], 32'd0, 31'd0, 10'd0);
    send_command(KIND_READ, 32'd0, 32'd0, 31'd0, 10'(g * GROUP_SIZE));
  endtask

  // One heavy flow runs into the count ceiling while its neighbors build up
  // counts high enough that decay becomes unlikely for newcomers.
  task automatic test_heavy_flow();
    int g;
    g = $urandom_range(0, NUM_GROUPS - 1);
    gather_group(g, 5);
    for (int i = 0; i < 270; i++)
      send_command(KIND_UPDATE, group_labels[0], $urandom(), any_random(), 10'd0);
    for (int i = 0; i < 45; i++)
      send_command(KIND_UPDATE, group_labels[1 + i % 3], $urandom(), any_random(), 10'd0);
    for (int i = 0; i < 25; i++)
      send_command(KIND_UPDATE, group_labels[4], $urandom(),
                   (i % 5 == 0) ? 31'd0 : any_random(), 10'd0);
    send_command(KIND_READ, 32'd0, 32'd0, 31'd0, 10'(g * GROUP_SIZE));
  endtask

  // Mostly updates on a crowd of labels packed into a few groups, with
  // queries, slot reads, stray labels and no-ops mixed in.
  task automatic test_random_traffic(input int items);
    int          pick;
    logic [31:0] label;
    logic [30:0] rnd;
    crowd_labels.delete();
    for (int g = 0; g < 8; g++) begin
      gather_group($urandom_range(0, NUM_GROUPS - 1), 10);
      foreach (group_labels[i])
        crowd_labels.push_back(group_labels[i]);
    end
    for (int n = 0; n < items; n++) begin
      no_gaps = (n >= items / 2) && (n < items / 2 + 200);
      label = ($urandom_range(0, 9) < 8) ?
              crowd_labels[$urandom_range(0, crowd_labels.size() - 1)] : $urandom();
      rnd   = ($urandom_range(0, 3) == 0) ? 31'd0 :
              ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 20)) : any_random();
      pick  = $urandom_range(0, 99);
      if (pick < 70)
        send_command(KIND_UPDATE, label, $urandom(), rnd, 10'($urandom()));
      else if (pick < 82)
        send_command(KIND_EXISTS, label, $urandom(), rnd, 10'($urandom()));
      else if (pick < 95)
        send_command(KIND_READ, $urandom(), $urandom(), rnd,
                     ($urandom_range(0, 1) == 0) ?
                     10'(group_of(label) * GROUP_SIZE + $urandom_range(0, 3)) :
                     10'($urandom()));
      else
        send_command(KIND_NOP, label, $urandom(), rnd, 10'($urandom()));
    end
    no_gaps = 1'b0;
  endtask

  // Every result transfer is checked against the oldest pending result.
  table_result_t observed;
  table_result_t predicted;

  always @(posedge clk) begin
    if (!rst && valid) begin
      observed = {action, slot_index, hash_value, partner_out, found,
                  slot_label, slot_count, last};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: %p", observed);
      end else begin
        predicted = pending_results.pop_front();
        if (observed !== predicted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", predicted, observed);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    kind          = KIND_NOP;
    flow_label    = '0;
    partner_label = '0;
    random_value  = '0;
    slot_location = '0;
    mismatches    = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shadow_labels[i] = '0;
      shadow_counts[i] = '0;
    end
    for (int g = 0; g < NUM_GROUPS; g++)
      shadow_fill[g] = 0;
    build_decay_divisors();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The clearing pass after reset shows up as busy; sending waits it out.
    test_empty_table();
    test_extreme_labels();
    test_full_group();
    test_heavy_flow();
    test_random_traffic(1200);

    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0)
      $display("grouped_flow_counter_table_tb passed");
    else
      $display("grouped_flow_counter_table_tb failed");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #1600000;
    $display("grouped_flow_counter_table_tb failed");
    $finish;
  end

endmodule
`default_nettype wire
